@@ rtl/espt_pkg.sv @@
// Shared widths, register indexes, reset values and constants for the encoder tracker.
package espt_pkg;

    localparam int COUNT_W = 16;
    localparam int POS_W   = 32;
    localparam int SPEED_W = 48;
    localparam int ANGLE_W = 25;
    localparam int CFG_W   = 32;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx REG_REV_COUNTS        = 2'd0;
    localparam t_cfg_idx REG_RPM_PER_COUNT     = 2'd1;
    localparam t_cfg_idx REG_WHEEL_RADIUS      = 2'd2;
    localparam t_cfg_idx REG_DEGREES_PER_COUNT = 2'd3;

    localparam logic [15:0] RST_REV_COUNTS        = 16'd1320;
    localparam logic [31:0] RST_RPM_PER_COUNT     = 32'd294912;
    localparam logic [15:0] RST_WHEEL_RADIUS      = 16'd2130;
    localparam logic [31:0] RST_DEGREES_PER_COUNT = 32'd17873;

    // pi/30 in Q0.16
    localparam logic [12:0] RAD_PER_RPM_Q16 = 13'd6863;
    // 360 degrees in Q16.16
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_Q16 = 25'd23592960;

endpackage

@@ rtl/espt_in_if.sv @@
// Input channel: kind and encoder counter reading with valid/ready.
interface espt_in_if import espt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [COUNT_W-1:0] counter_value;

    modport source (output valid, kind, counter_value, input ready);
    modport sink   (input valid, kind, counter_value, output ready);
endinterface

@@ rtl/espt_out_if.sv @@
// Result channel: delta, position, speeds and angle with valid/ready.
interface espt_out_if import espt_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COUNT_W-1:0] delta_counts;
    logic signed [POS_W-1:0]   position_counts;
    logic signed [SPEED_W-1:0] rpm_q16;
    logic signed [SPEED_W-1:0] omega_q16;
    logic signed [SPEED_W-1:0] lin_vel_q16;
    logic        [ANGLE_W-1:0] wheel_angle;

    modport source (output valid, delta_counts, position_counts, rpm_q16, omega_q16,
                    lin_vel_q16, wheel_angle, input ready);
    modport sink   (input valid, delta_counts, position_counts, rpm_q16, omega_q16,
                    lin_vel_q16, wheel_angle, output ready);
endinterface

@@ rtl/encoder_speed_position_tracker.sv @@
// Encoder tracker: delta, position, speeds via a shared 17x17 multiplier, angle via a serial divider.
// Sample word: multiply passes (rpm, rad/s, velocity), serial remainder, fold-up fixup, angle multiply,
// then hand-off to the result register; the next word is accepted only after hand-off. Resync word:
// goes straight to hand-off. Rate is set by the one-bit-per-cycle remainder loop and the chunked
// passes through the single multiplier; a held result register delays the hand-off.
// Synchronous active-low reset: registers back to defaults, last count and position zero, no result.
module encoder_speed_position_tracker import espt_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  t_cfg_idx        i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    espt_in_if.sink         i_in,
    espt_out_if.source      o_out
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [1:0] P_RPM = 2'd0;
    localparam logic [1:0] P_RAD = 2'd1;
    localparam logic [1:0] P_VEL = 2'd2;
    localparam logic [1:0] P_ANG = 2'd3;

    localparam logic signed [63:0] ROUND_INIT = 64'sd32768;

    // configuration
    logic [15:0] r_cpr;
    logic [31:0] r_rpc;
    logic [15:0] r_radius;
    logic [31:0] r_dpc;

    // control and tracking state
    logic [2:0]  r_state;
    logic [1:0]  r_pass;
    logic [1:0]  r_step;
    logic [4:0]  r_cnt;
    logic        r_ov;
    logic [COUNT_W-1:0] r_last;
    logic [POS_W-1:0]   r_position;

    // working registers
    logic signed [COUNT_W-1:0] r_delta;
    logic signed [SPEED_W-1:0] r_rpm;
    logic signed [SPEED_W-1:0] r_rad;
    logic signed [SPEED_W-1:0] r_vel;
    logic        [ANGLE_W-1:0] r_ang;
    logic signed [63:0]        r_acc;
    logic signed [33:0]        r_prod;
    logic [1:0]                r_prod_sh;
    logic [31:0]               r_dvd;
    logic [15:0]               r_rem;
    logic                      r_neg;
    logic [15:0]               r_mod;

    // output register
    logic signed [COUNT_W-1:0] r_o_delta;
    logic signed [POS_W-1:0]   r_o_position;
    logic signed [SPEED_W-1:0] r_o_rpm;
    logic signed [SPEED_W-1:0] r_o_rad;
    logic signed [SPEED_W-1:0] r_o_vel;
    logic        [ANGLE_W-1:0] r_o_ang;

    logic               w_accept;
    logic               w_load;
    logic [COUNT_W-1:0] w_d16;
    logic [POS_W-1:0]   w_pos_upd;
    logic signed [16:0] w_a;
    logic signed [16:0] w_b;
    logic signed [33:0] w_prod;
    logic signed [63:0] w_pp_ext;
    logic signed [63:0] w_pp;
    logic signed [63:0] w_sum;
    logic [1:0]         w_last_step;
    logic [16:0]        w_t;
    logic               w_ge;
    logic [15:0]        w_rem_n;

    // 16-bit chunk of a 48-bit signed word as a signed 17-bit operand
    function automatic logic signed [16:0] chunk48(input logic [47:0] v, input logic [1:0] s);
        logic signed [16:0] c;
        unique case (s)
            2'd0:    c = {1'b0, v[15:0]};
            2'd1:    c = {1'b0, v[31:16]};
            default: c = {v[47], v[47:32]};
        endcase
        return c;
    endfunction

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && (r_state == S_IDLE);
    assign w_load     = (r_state == S_DONE) && (!r_ov || o_out.ready);

    assign w_d16     = i_in.counter_value - r_last;
    assign w_pos_upd = r_position + {{(POS_W-COUNT_W){w_d16[COUNT_W-1]}}, w_d16};

    // multiplier operand select
    always_comb begin
        unique case (r_pass)
            P_RPM: begin
                w_a = {r_delta[15], r_delta};
                w_b = {1'b0, (r_step[0] ? r_rpc[31:16] : r_rpc[15:0])};
            end
            P_RAD: begin
                w_a = chunk48(r_rpm, r_step);
                w_b = {4'd0, RAD_PER_RPM_Q16};
            end
            P_VEL: begin
                w_a = chunk48(r_rad, r_step);
                w_b = {1'b0, r_radius};
            end
            default: begin
                w_a = {1'b0, r_mod};
                w_b = {1'b0, (r_step[0] ? r_dpc[31:16] : r_dpc[15:0])};
            end
        endcase
    end

    assign w_prod   = w_a * w_b;
    assign w_pp_ext = 64'(r_prod);

    always_comb begin
        unique case (r_prod_sh)
            2'd0:    w_pp = w_pp_ext;
            2'd1:    w_pp = w_pp_ext <<< 16;
            default: w_pp = w_pp_ext <<< 32;
        endcase
    end

    assign w_sum       = (r_step != 2'd0) ? (r_acc + w_pp) : r_acc;
    assign w_last_step = (r_pass == P_RAD || r_pass == P_VEL) ? 2'd3 : 2'd2;

    // restoring remainder step; partial remainder stays below a nonzero divisor
    assign w_t     = {r_rem, r_dvd[31]};
    assign w_ge    = (w_t >= {1'b0, r_cpr});
    assign w_rem_n = w_ge ? 16'(w_t - {1'b0, r_cpr}) : w_t[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pass     <= P_RPM;
            r_step     <= 2'd0;
            r_cnt      <= 5'd0;
            r_ov       <= 1'b0;
            r_last     <= '0;
            r_position <= '0;
            r_cpr      <= RST_REV_COUNTS;
            r_rpc      <= RST_RPM_PER_COUNT;
            r_radius   <= RST_WHEEL_RADIUS;
            r_dpc      <= RST_DEGREES_PER_COUNT;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_REV_COUNTS:        r_cpr    <= i_cfg_data[15:0];
                    REG_RPM_PER_COUNT:     r_rpc    <= i_cfg_data;
                    REG_WHEEL_RADIUS:      r_radius <= i_cfg_data[15:0];
                    REG_DEGREES_PER_COUNT: r_dpc    <= i_cfg_data;
                endcase
            end

            r_ov <= (r_ov && !o_out.ready) || w_load;

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_last <= i_in.counter_value;
                        r_pass <= P_RPM;
                        r_step <= 2'd0;
                        if (i_in.kind) begin
                            r_position <= w_pos_upd;
                            r_state    <= S_MUL;
                        end else begin
                            r_position <= '0;
                            r_state    <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    if (r_step == w_last_step) begin
                        r_step <= 2'd0;
                        unique case (r_pass)
                            P_RPM: begin
                                r_pass <= P_RAD;
                            end
                            P_RAD: begin
                                r_pass <= P_VEL;
                            end
                            P_VEL: begin
                                r_cnt   <= 5'd0;
                                r_state <= S_DIV;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end else begin
                        r_step <= r_step + 2'd1;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_pass  <= P_ANG;
                    r_step  <= 2'd0;
                    r_state <= S_MUL;
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_acc <= '0;
                if (i_in.kind) begin
                    r_delta <= w_d16;
                end else begin
                    r_delta <= '0;
                    r_rpm   <= '0;
                    r_rad   <= '0;
                    r_vel   <= '0;
                    r_ang   <= '0;
                end
            end
            S_MUL: begin
                if (r_step != w_last_step) begin
                    r_prod    <= w_prod;
                    r_prod_sh <= r_step;
                    r_acc     <= w_sum;
                end else begin
                    unique case (r_pass)
                        P_RPM: begin
                            r_rpm <= w_sum[47:0];
                            r_acc <= ROUND_INIT;
                        end
                        P_RAD: begin
                            r_rad <= w_sum[63:16];
                            r_acc <= ROUND_INIT;
                        end
                        P_VEL: begin
                            r_vel <= w_sum[63:16];
                            r_acc <= '0;
                            r_rem <= '0;
                            r_neg <= r_position[31];
                            r_dvd <= r_position[31] ? (~r_position + 32'd1) : r_position;
                        end
                        default: begin
                            r_ang <= ($unsigned(w_sum) > 64'(ANGLE_MAX_Q16))
                                     ? ANGLE_MAX_Q16 : w_sum[ANGLE_W-1:0];
                        end
                    endcase
                end
            end
            S_DIV: begin
                r_rem <= w_rem_n;
                r_dvd <= {r_dvd[30:0], 1'b0};
            end
            S_MOD: begin
                // zero divisor gives angle zero; negative position folds into range
                if (r_cpr == 16'd0) begin
                    r_mod <= '0;
                end else if (r_neg && (r_rem != 16'd0)) begin
                    r_mod <= r_cpr - r_rem;
                end else begin
                    r_mod <= r_rem;
                end
                r_acc <= '0;
            end
            default: begin
            end
        endcase

        if (w_load) begin
            r_o_delta    <= r_delta;
            r_o_position <= r_position;
            r_o_rpm      <= r_rpm;
            r_o_rad      <= r_rad;
            r_o_vel      <= r_vel;
            r_o_ang      <= r_ang;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.delta_counts    = r_o_delta;
    assign o_out.position_counts = r_o_position;
    assign o_out.rpm_q16         = r_o_rpm;
    assign o_out.omega_q16       = r_o_rad;
    assign o_out.lin_vel_q16     = r_o_vel;
    assign o_out.wheel_angle     = r_o_ang;

endmodule
